FILE: rtl/core/priority_voice_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voice allocator
// Shared concurrent check forms, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_VOICE_ALLOCATOR_ASSERT_SVH
`define PRIORITY_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define PVA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PVA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Sizes, beat types and microcode types for the voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int NUM_VOICES    = 128;
  localparam int PRIORITY_BITS = 8;
  localparam int SLOT_W        = $clog2(NUM_VOICES);

  // Input beat.
  typedef struct packed {
    logic       cmd;
    logic [7:0] request_priority;
    logic [6:0] release_slot;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic       ok;
    logic [6:0] granted_slot;
    logic       stolen;
  } out_item_t;

  // Command code of an input beat.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Microprogram steps.
  typedef enum logic [2:0] {
    ST_FETCH,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT,
    ST_RELEASE
  } step_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_RELEASE,
    C_SCAN_MORE,
    C_OUT_BUSY
  } cond_e;

  // Datapath actions of one control word.
  typedef struct packed {
    logic take_in;
    logic clr_scan;
    logic issue;
    logic grant;
    logic release_op;
  } act_t;

  // One control word of the microprogram.
  typedef struct packed {
    act_t  act;
    cond_e cond;
    step_e tgt_t;
    step_e tgt_f;
  } ctrl_word_t;

  // Status flags sampled by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic is_release;
    logic scan_more;
    logic out_busy;
  } flags_t;

endpackage

FILE: rtl/core/priority_voice_allocator.sv
// ----------------------------------------------------------------------------
// priority_voice_allocator
// Grants playback voices by priority and steals the weakest when full.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_item_i): one beat per command.
// cmd allocate asks for a voice at request_priority; cmd release frees the
// voice named by release_slot. Output channel (out_valid_o / out_stall_i /
// out_item_o) returns exactly one beat per command, in order.
// An allocate walks every voice through the priority store, one entry a
// cycle on its single read port; a release skips the scan.
// The next command is accepted in the cycle after its result is loaded, while
// that result may still sit in the output register.
// At reset all voices are inactive; the priority store is not cleared.
// While the receiver stalls, the result is held; the sequencer can still take a
// further command, but waits in the result or release step to load its result.
// ----------------------------------------------------------------------------
module priority_voice_allocator
  import pva_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  act_t   act;
  flags_t flags;

  // Microcode sequencer.
  pva_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .act_o   (act)
  );

  // Datapath.
  pva_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .act_i       (act),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .flags_o     (flags),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // Inputs are taken only in the fetch step.
  assign in_stall_o = ~act.take_in;

endmodule

FILE: rtl/core/pva_ram.sv
// ----------------------------------------------------------------------------
// pva_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pva_useq.sv
// ----------------------------------------------------------------------------
// pva_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module pva_useq
  import pva_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output act_t   act_o
);

  step_e      step_q, step_d;
  ctrl_word_t word;
  logic       cond_hit;

  // Control store. Each word names its actions, a condition and two targets.
  function automatic ctrl_word_t rom(step_e s);
    ctrl_word_t w;
    w = '{act: '0, cond: C_ALWAYS, tgt_t: ST_FETCH, tgt_f: ST_FETCH};
    case (s)
      ST_FETCH: begin
        w.act.take_in = 1'b1;
        w.cond  = C_IN_VALID;
        w.tgt_t = ST_DISPATCH;
        w.tgt_f = ST_FETCH;
      end
      ST_DISPATCH: begin
        w.act.clr_scan = 1'b1;
        w.cond  = C_RELEASE;
        w.tgt_t = ST_RELEASE;
        w.tgt_f = ST_SCAN;
      end
      ST_SCAN: begin
        w.act.issue = 1'b1;
        w.cond  = C_SCAN_MORE;
        w.tgt_t = ST_SCAN;
        w.tgt_f = ST_DRAIN;
      end
      ST_DRAIN: begin
        w.cond  = C_ALWAYS;
        w.tgt_t = ST_RESULT;
        w.tgt_f = ST_RESULT;
      end
      ST_RESULT: begin
        w.act.grant = 1'b1;
        w.cond  = C_OUT_BUSY;
        w.tgt_t = ST_RESULT;
        w.tgt_f = ST_FETCH;
      end
      ST_RELEASE: begin
        w.act.release_op = 1'b1;
        w.cond  = C_OUT_BUSY;
        w.tgt_t = ST_RELEASE;
        w.tgt_f = ST_FETCH;
      end
      default: begin
        w.cond  = C_ALWAYS;
        w.tgt_t = ST_FETCH;
        w.tgt_f = ST_FETCH;
      end
    endcase
    return w;
  endfunction

  // Fetch the current word and evaluate its condition.
  always_comb begin
    word = rom(step_q);
    case (word.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_IN_VALID:  cond_hit = flags_i.in_valid;
      C_RELEASE:   cond_hit = flags_i.is_release;
      C_SCAN_MORE: cond_hit = flags_i.scan_more;
      C_OUT_BUSY:  cond_hit = flags_i.out_busy;
      default:     cond_hit = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    step_d = cond_hit ? word.tgt_t : word.tgt_f;
  end

  // Actions driven into the datapath.
  always_comb begin
    act_o = word.act;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: rtl/core/pva_datapath.sv
// ----------------------------------------------------------------------------
// pva_datapath
// Active bits, scan trackers, priority store and result register.
// ----------------------------------------------------------------------------
`include "priority_voice_allocator_assert.svh"

module pva_datapath
  import pva_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  act_t      act_i,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  input  logic      out_stall_i,
  output flags_t    flags_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  in_item_t                item_q;
  logic [NUM_VOICES-1:0]   active_q, active_d;
  logic [SLOT_W-1:0]       scan_idx_q, scan_idx_d;
  logic [SLOT_W-1:0]       acc_idx_q;
  logic                    acc_act_q;
  logic                    rd_vld_q;
  logic                    free_found_q, free_found_d;
  logic [SLOT_W-1:0]       free_slot_q, free_slot_d;
  logic                    steal_found_q, steal_found_d;
  logic [SLOT_W-1:0]       steal_slot_q, steal_slot_d;
  logic [PRIORITY_BITS-1:0] steal_prio_q, steal_prio_d;
  logic [PRIORITY_BITS-1:0] req_prio;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;
  logic                    out_busy;
  logic                    grant_fire, release_fire;
  logic                    ram_we;
  logic [SLOT_W-1:0]       grant_idx;
  logic [SLOT_W-1:0]       rel_idx;
  logic                    rel_in_range;

  assign req_prio     = PRIORITY_BITS'(item_q.request_priority);
  assign rel_idx      = SLOT_W'(item_q.release_slot);
  assign rel_in_range = 32'(item_q.release_slot) < 32'(NUM_VOICES);
  assign out_busy     = out_valid_q & out_stall_i;
  assign grant_fire   = act_i.grant & ~out_busy;
  assign release_fire = act_i.release_op & ~out_busy;

  // Status flags for the sequencer.
  always_comb begin
    flags_o.in_valid   = in_valid_i;
    flags_o.is_release = (item_q.cmd == CMD_RELEASE);
    flags_o.scan_more  = (scan_idx_q != SLOT_W'(NUM_VOICES - 1));
    flags_o.out_busy   = out_busy;
  end

  // Priority store, read one entry a cycle during the scan.
  pva_ram #(
    .WIDTH (PRIORITY_BITS),
    .DEPTH (NUM_VOICES)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (grant_idx),
    .wdata_i (req_prio),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_prio)
  );

  // Scan counter and trackers. The first inactive voice and the weakest
  // active voice not above the request are kept as the entries stream by.
  always_comb begin
    scan_idx_d    = scan_idx_q;
    free_found_d  = free_found_q;
    free_slot_d   = free_slot_q;
    steal_found_d = steal_found_q;
    steal_slot_d  = steal_slot_q;
    steal_prio_d  = steal_prio_q;
    if (act_i.clr_scan) begin
      scan_idx_d    = '0;
      free_found_d  = 1'b0;
      steal_found_d = 1'b0;
    end else begin
      if (act_i.issue) begin
        scan_idx_d = scan_idx_q + 1'b1;
      end
      if (rd_vld_q) begin
        if (!acc_act_q && !free_found_q) begin
          free_found_d = 1'b1;
          free_slot_d  = acc_idx_q;
        end
        if (acc_act_q && (rd_prio <= req_prio) &&
            (!steal_found_q || (rd_prio < steal_prio_q))) begin
          steal_found_d = 1'b1;
          steal_slot_d  = acc_idx_q;
          steal_prio_d  = rd_prio;
        end
      end
    end
  end

  // Grant choice and the result of the current command.
  always_comb begin
    grant_idx = free_found_q ? free_slot_q : steal_slot_q;
    ram_we    = grant_fire & (free_found_q | steal_found_q);
    active_d  = active_q;
    out_d     = out_q;
    if (grant_fire) begin
      out_d.ok           = free_found_q | steal_found_q;
      out_d.granted_slot = (free_found_q | steal_found_q) ? 7'(grant_idx) : 7'd0;
      out_d.stolen       = ~free_found_q & steal_found_q;
      if (free_found_q | steal_found_q) begin
        active_d[grant_idx] = 1'b1;
      end
    end else if (release_fire) begin
      out_d.ok           = rel_in_range & active_q[rel_idx];
      out_d.granted_slot = 7'd0;
      out_d.stolen       = 1'b0;
      if (rel_in_range) begin
        active_d[rel_idx] = 1'b0;
      end
    end
    out_valid_d = grant_fire | release_fire | out_busy;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= '0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      scan_idx_q    <= '0;
      free_found_q  <= 1'b0;
      steal_found_q <= 1'b0;
    end else begin
      active_q      <= active_d;
      rd_vld_q      <= act_i.issue;
      out_valid_q   <= out_valid_d;
      scan_idx_q    <= scan_idx_d;
      free_found_q  <= free_found_d;
      steal_found_q <= steal_found_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (act_i.take_in && in_valid_i) begin
      item_q <= in_item_i;
    end
    acc_idx_q    <= scan_idx_q;
    acc_act_q    <= active_q[scan_idx_q];
    free_slot_q  <= free_slot_d;
    steal_slot_q <= steal_slot_d;
    steal_prio_q <= steal_prio_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PVA_ASSERT_NOW(a_no_overwrite, (grant_fire || release_fire), !out_busy,
    "result loaded while the previous beat is still stalled")
  `PVA_ASSERT_NOW(a_stolen_ok, (out_valid_q && out_q.stolen), out_q.ok,
    "stolen flag set on a failed result")
  `PVA_ASSERT_NXT(a_grant_active, ram_we, active_q[$past(grant_idx)],
    "granted voice not marked active")
  `PVA_ASSERT_NOW(a_scan_exclusive, rd_vld_q, (!grant_fire && !release_fire),
    "result produced while the scan is still streaming")

endmodule

FILE: tb/tb_priority_voice_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives allocate and release beats with bursty pacing against a randomly
// stalling receiver, predicts every result from a private copy of the voice
// table, and checks each result beat in order against the prediction.
// ----------------------------------------------------------------------------
module tb_priority_voice_allocator;
  import pva_pkg::*;

  localparam real         CLK_PERIOD   = 4.0;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned SETTLE_WAIT  = 300;

  // Mix of commands within one round of the random part.
  typedef enum int {
    MIX_FILL,
    MIX_CHURN,
    MIX_DRAIN
  } cmd_mix_e;

  // Range from which request priorities are drawn.
  typedef enum int {
    PR_FULL,
    PR_LOW,
    PR_HIGH,
    PR_EXTREME
  } prio_mix_e;

  // Voice table tracker and in-order store of expected result beats.
  class voice_scoreboard;
    bit                       active [NUM_VOICES];
    logic [PRIORITY_BITS-1:0] prio   [NUM_VOICES];
    out_item_t                expected_q[$];
    int unsigned              errors;

    function new();
      errors = 0;
      foreach (active[i]) begin
        active[i] = 1'b0;
        prio[i]   = '0;
      end
    endfunction

    // Work out the result of one accepted command and update the table.
    function void note_input(in_item_t it);
      out_item_t                res;
      logic [PRIORITY_BITS-1:0] req_p;
      logic [PRIORITY_BITS-1:0] best_p;
      int unsigned              best;
      bit                       found;
      bit                       done;
      res    = '0;
      req_p  = it.request_priority[PRIORITY_BITS-1:0];
      best_p = '0;
      best   = 0;
      found  = 1'b0;
      done   = 1'b0;
      if (it.cmd == CMD_RELEASE) begin
        if (it.release_slot < NUM_VOICES && active[it.release_slot]) begin
          active[it.release_slot] = 1'b0;
          res.ok = 1'b1;
        end
      end else begin
        // The lowest-numbered free voice wins outright.
        for (int i = 0; i < NUM_VOICES && !done; i++) begin
          if (!active[i]) begin
            active[i]        = 1'b1;
            prio[i]          = req_p;
            res.ok           = 1'b1;
            res.granted_slot = 7'(i);
            done             = 1'b1;
          end
        end
        // Pool full: steal the weakest voice not above the request.
        if (!done) begin
          for (int i = 0; i < NUM_VOICES; i++) begin
            if (prio[i] <= req_p && (!found || prio[i] < best_p)) begin
              found  = 1'b1;
              best   = i;
              best_p = prio[i];
            end
          end
          if (found) begin
            prio[best]       = req_p;
            res.ok           = 1'b1;
            res.granted_slot = 7'(best);
            res.stolen       = 1'b1;
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: result beat with nothing expected, got ok=%0d slot=%0d stolen=%0d",
                   got.ok, got.granted_slot, got.stolen);
        end
      end else begin
        exp = expected_q.pop_front();
        if (got.ok !== exp.ok || got.granted_slot !== exp.granted_slot ||
            got.stolen !== exp.stolen) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at %0t: expected ok=%0d slot=%0d stolen=%0d, got ok=%0d slot=%0d stolen=%0d",
                     $realtime, exp.ok, exp.granted_slot, exp.stolen,
                     got.ok, got.granted_slot, got.stolen);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // A random voice that is active now, or any voice if none is.
    function int unsigned pick_active();
      int unsigned idx_q[$];
      foreach (active[i]) begin
        if (active[i]) idx_q.push_back(i);
      end
      if (idx_q.size() == 0) return $urandom_range(0, NUM_VOICES - 1);
      return idx_q[$urandom_range(0, idx_q.size() - 1)];
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  voice_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_run = 0;
  int unsigned stall_sel;
  bit          stall_now = 1'b0;

  priority_voice_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // Both handshakes are sampled at the edge; inputs are noted before results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("tb_priority_voice_allocator NOT OK");
        $finish;
      end
    end
  end

  // Receiver stall pattern: short flickers, long holds and quiet stretches.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_sel = $urandom_range(0, 9);
      if (stall_sel < 4) begin
        stall_now = 1'b0;
        stall_run = $urandom_range(1, 10);
      end else if (stall_sel < 7) begin
        stall_now = 1'b1;
        stall_run = $urandom_range(1, 6);
      end else if (stall_sel < 9) begin
        stall_now = 1'b1;
        stall_run = $urandom_range(20, 60);
      end else begin
        stall_now = 1'b0;
        stall_run = $urandom_range(200, 600);
      end
    end
    stall_run--;
    out_stall_i <= stall_now;
  end

  // Send one beat, wait for it to be taken, then apply the sender's pacing.
  task automatic issue(input logic cmd, input logic [7:0] prio, input logic [6:0] slot);
    in_item_t it;
    int unsigned gap;
    it.cmd              = cmd;
    it.request_priority = prio;
    it.release_slot     = slot;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // End of a burst: idle for a while, then start a new one.
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 30);
    end
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] draw_prio(prio_mix_e pm);
    case (pm)
      PR_LOW:     return 8'($urandom_range(0, 3));
      PR_HIGH:    return 8'($urandom_range(248, 255));
      PR_EXTREME: return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned round_len;
    int unsigned cmd_roll;
    int unsigned alloc_pct;
    cmd_mix_e    cm;
    prio_mix_e   pm;
    logic        cmd;
    logic [6:0]  slot;
    bit          first_round;

    sent        = 0;
    first_round = 1'b1;
    burst_left  = $urandom_range(1, 30);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: releases of idle voices, extreme priorities, reuse of a freed voice.
    issue(CMD_RELEASE, 8'h00, 7'd0);
    issue(CMD_RELEASE, 8'hFF, 7'd127);
    issue(CMD_ALLOC,   8'hFF, 7'd127);
    issue(CMD_ALLOC,   8'h00, 7'd0);
    issue(CMD_ALLOC,   8'h80, 7'h55);
    issue(CMD_RELEASE, 8'h2A, 7'd1);
    issue(CMD_RELEASE, 8'h2A, 7'd1);
    issue(CMD_ALLOC,   8'h01, 7'h2A);
    issue(CMD_RELEASE, 8'h00, 7'd0);
    issue(CMD_ALLOC,   8'h7F, 7'd127);
    issue(CMD_RELEASE, 8'hFF, 7'd127);
    issue(CMD_RELEASE, 8'h00, 7'd2);
    issue(CMD_RELEASE, 8'h00, 7'd1);
    issue(CMD_RELEASE, 8'h00, 7'd0);
    issue(CMD_ALLOC,   8'hFF, 7'd0);
    wait_drained();

    // Random rounds; the first one fills the pool so stealing starts early.
    while (sent < RANDOM_ITEMS) begin
      if (first_round) begin
        cm        = MIX_FILL;
        pm        = PR_LOW;
        round_len = 140;
      end else begin
        cm        = cmd_mix_e'($urandom_range(0, 2));
        pm        = prio_mix_e'($urandom_range(0, 3));
        round_len = $urandom_range(20, 150);
      end
      case (cm)
        MIX_FILL:  alloc_pct = 95;
        MIX_DRAIN: alloc_pct = 15;
        default:   alloc_pct = 50;
      endcase
      for (int n = 0; n < round_len && sent < RANDOM_ITEMS; n++) begin
        cmd_roll = $urandom_range(0, 99);
        cmd      = (cmd_roll < alloc_pct) ? CMD_ALLOC : CMD_RELEASE;
        if (cmd == CMD_RELEASE && $urandom_range(0, 9) < 6) begin
          slot = 7'(sb.pick_active());
        end else begin
          slot = 7'($urandom_range(0, 127));
        end
        issue(cmd, draw_prio(pm), slot);
        sent++;
      end
      if (first_round || $urandom_range(0, 3) == 0) wait_drained();
      first_round = 1'b0;
    end

    // Let the last results arrive and watch for stray beats afterwards.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);

    if (sb.pending() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("tb_priority_voice_allocator OK");
    end else begin
      $display("tb_priority_voice_allocator NOT OK");
    end
    $finish;
  end

endmodule
